// ===== design/voxel_grid_trilinear_sample_splat_defines.svh =====
// Assertion macros for the voxel grid block.
// Needs nothing else; files that assert include it by name.
`ifndef VOXEL_GRID_TRILINEAR_SAMPLE_SPLAT_DEFINES_SVH
`define VOXEL_GRID_TRILINEAR_SAMPLE_SPLAT_DEFINES_SVH
`ifndef ASSERT_OFF
`define VGTS_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("vgts assertion failed");
`define VGTS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("vgts assertion failed");
`else
`define VGTS_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define VGTS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// ===== design/vgts_pkg.sv =====
// Shared types, constants and helpers of the voxel grid block.
// Used by vgts_div and voxel_grid_trilinear_sample_splat.
package vgts_pkg;

    localparam int MAX_EXTENT_DEF = 32;
    localparam int MAX_RADIUS_DEF = 4;

    localparam int RW    = 5;   // effective radius, up to 16
    localparam int OFW   = 6;   // neighbor offset, -15..16
    localparam int WAW   = 21;  // per-axis weight, up to r * 2^16
    localparam int MA_W  = 33;  // shared multiplier operand a
    localparam int MB_W  = 25;  // shared multiplier operand b
    localparam int MP_W  = 58;  // shared multiplier product
    localparam int IPW   = 28;  // grid-relative corner coordinate
    localparam int ACW   = 52;  // sample accumulator
    localparam int DVD_W = 29;  // dividend, product >> 32
    localparam int DVS_W = 25;  // divisor r^6
    localparam int QW    = 17;  // weight, at most 2^16

    typedef enum logic [2:0] {
        CMD_WRITE  = 3'd0,
        CMD_READ   = 3'd1,
        CMD_SAMPLE = 3'd2,
        CMD_SPLAT  = 3'd3,
        CMD_LARGE  = 3'd4
    } cmd_t;

    typedef enum logic [2:0] {
        CFG_ORIGIN_X    = 3'd0,
        CFG_ORIGIN_Y    = 3'd1,
        CFG_ORIGIN_Z    = 3'd2,
        CFG_EXTENT_X    = 3'd3,
        CFG_EXTENT_Y    = 3'd4,
        CFG_EXTENT_Z    = 3'd5,
        CFG_INV_SPACING = 3'd6
    } cfg_idx_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_RD_WAIT,
        ST_LOC_X,
        ST_LOC_Y,
        ST_LOC_Z,
        ST_LOC_END,
        ST_NB_CHECK,
        ST_NB_ADDR,
        ST_WT_B,
        ST_WT_C,
        ST_DIV,
        ST_MEM_USE,
        ST_ACC,
        ST_FINISH
    } vgts_state_t;

    // r^6 for the large splat divisor
    function automatic logic [DVS_W-1:0] pow6(input logic [RW-1:0] r);
        logic [DVS_W-1:0] p;
        unique case (r)
            5'd0:    p = 25'd0;
            5'd1:    p = 25'd1;
            5'd2:    p = 25'd64;
            5'd3:    p = 25'd729;
            5'd4:    p = 25'd4096;
            5'd5:    p = 25'd15625;
            5'd6:    p = 25'd46656;
            5'd7:    p = 25'd117649;
            5'd8:    p = 25'd262144;
            5'd9:    p = 25'd531441;
            5'd10:   p = 25'd1000000;
            5'd11:   p = 25'd1771561;
            5'd12:   p = 25'd2985984;
            5'd13:   p = 25'd4826809;
            5'd14:   p = 25'd7529536;
            5'd15:   p = 25'd11390625;
            5'd16:   p = 25'd16777216;
            default: p = 25'd0;
        endcase
        return p;
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
        logic signed [31:0] y;
        if (x > 64'sd2147483647)
            y = 32'sh7FFFFFFF;
        else if (x < -64'sd2147483648)
            y = 32'sh80000000;
        else
            y = x[31:0];
        return y;
    endfunction

    // tent weight r - |d - a| in Q.16; r = 1 gives the trilinear weights
    function automatic logic [WAW-1:0] axis_weight(input logic [OFW-1:0] d,
                                                   input logic [15:0] a,
                                                   input logic [RW-1:0] r);
        logic signed [OFW+16:0] t;
        logic [OFW+16:0] mag;
        t = $signed({d[OFW-1], d, 16'h0000}) - $signed({{(OFW+1){1'b0}}, a});
        mag = t[OFW+16] ? (OFW+17)'(-t) : (OFW+17)'(t);
        return {r, 16'h0000} - mag[WAW-1:0];
    endfunction

endpackage

// ===== design/voxel_grid_trilinear_sample_splat.sv =====
// Voxel grid: write, read, trilinear sample/splat and tent splat on a Q16.16 grid.
// One item at a time: a new item is taken only in idle. Sample/splat and large splat
// walk (2r)^3 neighbor visits, with r = 1 for the trilinear commands.
// Single-port memory and the serial weight divider set how long an item takes.
// After reset a clearing pass zeroes MAX_EXTENT^3 entries with stall high.
// Uses vgts_pkg, vgts_store, vgts_div and the defines header.
`include "voxel_grid_trilinear_sample_splat_defines.svh"

module voxel_grid_trilinear_sample_splat #(
    parameter int MAX_EXTENT = vgts_pkg::MAX_EXTENT_DEF,
    parameter int MAX_RADIUS = vgts_pkg::MAX_RADIUS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    // item input
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [2:0]         command,
    input  logic [14:0]        voxel_index,
    input  logic signed [31:0] pos_x,
    input  logic signed [31:0] pos_y,
    input  logic signed [31:0] pos_z,
    input  logic signed [31:0] value,
    input  logic [2:0]         radius,
    // result output
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [31:0] result_value,
    // register writes
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [2:0]         cfg_index,
    input  logic [23:0]        cfg_data
);

    localparam int DEPTH = MAX_EXTENT * MAX_EXTENT * MAX_EXTENT;
    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = $clog2(MAX_EXTENT);
    localparam int EW    = $clog2(MAX_EXTENT + 1);
    localparam int TW    = $clog2(MAX_EXTENT * MAX_EXTENT);

    localparam int RW    = vgts_pkg::RW;
    localparam int OFW   = vgts_pkg::OFW;
    localparam int WAW   = vgts_pkg::WAW;
    localparam int MA_W  = vgts_pkg::MA_W;
    localparam int MB_W  = vgts_pkg::MB_W;
    localparam int MP_W  = vgts_pkg::MP_W;
    localparam int IPW   = vgts_pkg::IPW;
    localparam int ACW   = vgts_pkg::ACW;
    localparam int DVD_W = vgts_pkg::DVD_W;
    localparam int DVS_W = vgts_pkg::DVS_W;
    localparam int QW    = vgts_pkg::QW;

    // ---------------------------------------------------------------
    // Configuration registers
    // ---------------------------------------------------------------
    logic signed [15:0] origin_x_reg, origin_y_reg, origin_z_reg;
    logic [5:0]         extent_x_reg, extent_y_reg, extent_z_reg;
    logic [23:0]        inv_spacing_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            origin_x_reg    <= '0;
            origin_y_reg    <= '0;
            origin_z_reg    <= '0;
            extent_x_reg    <= 6'd32;
            extent_y_reg    <= 6'd32;
            extent_z_reg    <= 6'd32;
            inv_spacing_reg <= 24'd65536;
        end
        else if (cfg_valid)
        begin
            unique case (vgts_pkg::cfg_idx_t'(cfg_index))
                vgts_pkg::CFG_ORIGIN_X:    origin_x_reg    <= cfg_data[15:0];
                vgts_pkg::CFG_ORIGIN_Y:    origin_y_reg    <= cfg_data[15:0];
                vgts_pkg::CFG_ORIGIN_Z:    origin_z_reg    <= cfg_data[15:0];
                vgts_pkg::CFG_EXTENT_X:    extent_x_reg    <= cfg_data[5:0];
                vgts_pkg::CFG_EXTENT_Y:    extent_y_reg    <= cfg_data[5:0];
                vgts_pkg::CFG_EXTENT_Z:    extent_z_reg    <= cfg_data[5:0];
                vgts_pkg::CFG_INV_SPACING: inv_spacing_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // extents clamp to the grid size
    logic [EW-1:0] ex_eff, ey_eff, ez_eff;
    assign ex_eff = (int'(extent_x_reg) > MAX_EXTENT) ? EW'(MAX_EXTENT) : EW'(extent_x_reg);
    assign ey_eff = (int'(extent_y_reg) > MAX_EXTENT) ? EW'(MAX_EXTENT) : EW'(extent_y_reg);
    assign ez_eff = (int'(extent_z_reg) > MAX_EXTENT) ? EW'(MAX_EXTENT) : EW'(extent_z_reg);

    // ---------------------------------------------------------------
    // State and working registers
    // ---------------------------------------------------------------
    vgts_pkg::vgts_state_t state_reg, state_next;

    logic [AW-1:0]       clr_cnt_reg;
    logic                out_valid_reg;
    logic signed [31:0]  result_value_reg;

    vgts_pkg::cmd_t      cmd_reg;
    logic signed [31:0]  pos_x_reg, pos_y_reg, pos_z_reg, val_reg;
    logic [RW-1:0]       r_reg;
    logic [DVS_W-1:0]    d_reg;
    logic                rd_ok_reg;
    logic signed [31:0]  rd_res_reg;

    logic [IPW-1:0]      ix_reg, iy_reg, iz_reg;
    logic [15:0]         ax_reg, ay_reg, az_reg;
    logic [OFW-1:0]      dx_reg, dy_reg, dz_reg;
    logic [TW-1:0]       t_reg;
    logic [AW-1:0]       addr_reg;
    logic [40:0]         wxy_reg;
    logic [41:0]         lo_reg;
    logic [QW-1:0]       w_reg;
    logic signed [ACW-1:0] acc_reg;
    logic signed [MP_W-1:0] prod_reg;

    // ---------------------------------------------------------------
    // Handshake decode
    // ---------------------------------------------------------------
    logic           accept;
    vgts_pkg::cmd_t cmd_in;
    logic           vidx_ok;
    logic [AW-1:0]  vidx_addr;
    logic [RW-1:0]  r_in;

    assign accept    = in_valid && !in_stall;
    assign cmd_in    = vgts_pkg::cmd_t'(command);
    assign vidx_ok   = 32'(voxel_index) < 32'(DEPTH);
    assign vidx_addr = AW'(voxel_index);
    // trilinear work runs as a radius-one kernel
    assign r_in = (cmd_in != vgts_pkg::CMD_LARGE) ? RW'(1) :
                  (int'(radius) > MAX_RADIUS) ? RW'(MAX_RADIUS) : RW'(radius);

    // ---------------------------------------------------------------
    // Locate: floor(p * inv / 2^16) - 0.5, split into corner (less the origin) and fraction
    // ---------------------------------------------------------------
    logic signed [15:0]     org_sel;
    logic signed [MP_W-17:0] fl16;
    logic signed [MP_W-16:0] vq;
    logic [IPW-1:0]         loc_ip;
    logic [15:0]            loc_alpha;

    always_comb
    begin
        priority if (state_reg == vgts_pkg::ST_LOC_Y)
            org_sel = origin_x_reg;
        else if (state_reg == vgts_pkg::ST_LOC_Z)
            org_sel = origin_y_reg;
        else
            org_sel = origin_z_reg;
        fl16      = prod_reg[MP_W-1:16];
        vq        = $signed({fl16[MP_W-17], fl16}) - (MP_W-15)'(32768);
        loc_alpha = vq[15:0];
        loc_ip    = IPW'($signed(vq[MP_W-16:16])) - IPW'(org_sel);
    end

    // ---------------------------------------------------------------
    // Neighbor walk: coordinates, bounds, weights, addresses
    // ---------------------------------------------------------------
    logic [OFW-1:0] off_hi, off_lo;
    logic [IPW-1:0] cx, cy, cz;
    logic           nb_in;
    logic [WAW-1:0] wx, wy, wz;
    logic [TW-1:0]  t_calc;
    logic [AW-1:0]  addr_calc;
    logic           last_nb;
    logic [OFW-1:0] dx_adv, dy_adv, dz_adv;
    logic           is_large;
    logic [61:0]    big_p;
    logic [DVD_W-1:0] div_dvd;

    assign off_hi   = OFW'(r_reg);
    assign off_lo   = OFW'(1) - OFW'(r_reg);
    assign is_large = (cmd_reg == vgts_pkg::CMD_LARGE);

    always_comb
    begin
        cx = ix_reg + {{(IPW-OFW){dx_reg[OFW-1]}}, dx_reg};
        cy = iy_reg + {{(IPW-OFW){dy_reg[OFW-1]}}, dy_reg};
        cz = iz_reg + {{(IPW-OFW){dz_reg[OFW-1]}}, dz_reg};
        nb_in = !cx[IPW-1] && (cx < IPW'(ex_eff)) &&
                !cy[IPW-1] && (cy < IPW'(ey_eff)) &&
                !cz[IPW-1] && (cz < IPW'(ez_eff));
        wx = vgts_pkg::axis_weight(dx_reg, ax_reg, r_reg);
        wy = vgts_pkg::axis_weight(dy_reg, ay_reg, r_reg);
        wz = vgts_pkg::axis_weight(dz_reg, az_reg, r_reg);
        // linear address x + ex*(y + ey*z), one product per cycle
        t_calc    = TW'((TW+EW)'(cy[CW-1:0]) + (TW+EW)'(ey_eff) * (TW+EW)'(cz[CW-1:0]));
        addr_calc = AW'((AW+EW)'(cx[CW-1:0]) + (AW+EW)'(ex_eff) * (AW+EW)'(t_reg));
        // hi*wz shifted plus lo*wz, then >> 32 for the divider
        big_p   = {prod_reg[40:0], 21'h0} + 62'(lo_reg);
        div_dvd = big_p[60:32];
    end

    always_comb
    begin
        last_nb = (dx_reg == off_hi) && (dy_reg == off_hi) && (dz_reg == off_hi);
        dx_adv  = dx_reg + OFW'(1);
        dy_adv  = dy_reg;
        dz_adv  = dz_reg;
        if (dx_reg == off_hi)
        begin
            dx_adv = off_lo;
            dy_adv = dy_reg + OFW'(1);
            if (dy_reg == off_hi)
            begin
                dy_adv = off_lo;
                dz_adv = dz_reg + OFW'(1);
            end
        end
    end

    // ---------------------------------------------------------------
    // Memory and divider
    // ---------------------------------------------------------------
    logic          mem_en, mem_we;
    logic [AW-1:0] mem_addr;
    logic [31:0]   mem_wdata;
    logic [31:0]   rdata;
    logic          div_start, div_done;
    logic [QW-1:0] div_q;
    logic signed [31:0] splat_sum;

    assign splat_sum = vgts_pkg::sat32(64'($signed(rdata)) +
                                       64'($signed(prod_reg[MP_W-1:16])));

    vgts_store #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_store (
        .clk   (clk),
        .en    (mem_en),
        .we    (mem_we),
        .addr  (mem_addr),
        .wdata (mem_wdata),
        .rdata (rdata)
    );

    vgts_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dvd),
        .divisor  (d_reg),
        .quotient (div_q),
        .done     (div_done)
    );

    // ---------------------------------------------------------------
    // Next state
    // ---------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            vgts_pkg::ST_CLEAR:
                if (clr_cnt_reg == AW'(DEPTH - 1))
                    state_next = vgts_pkg::ST_IDLE;
            vgts_pkg::ST_IDLE:
                if (accept)
                begin
                    unique case (cmd_in)
                        vgts_pkg::CMD_READ:   state_next = vgts_pkg::ST_RD_WAIT;
                        vgts_pkg::CMD_SAMPLE,
                        vgts_pkg::CMD_SPLAT,
                        vgts_pkg::CMD_LARGE:  state_next = vgts_pkg::ST_LOC_X;
                        default:              state_next = vgts_pkg::ST_FINISH;
                    endcase
                end
            vgts_pkg::ST_RD_WAIT: state_next = vgts_pkg::ST_FINISH;
            vgts_pkg::ST_LOC_X:   state_next = vgts_pkg::ST_LOC_Y;
            vgts_pkg::ST_LOC_Y:   state_next = vgts_pkg::ST_LOC_Z;
            vgts_pkg::ST_LOC_Z:   state_next = vgts_pkg::ST_LOC_END;
            vgts_pkg::ST_LOC_END:
                state_next = (r_reg == '0) ? vgts_pkg::ST_FINISH : vgts_pkg::ST_NB_CHECK;
            vgts_pkg::ST_NB_CHECK:
                priority if (nb_in)
                    state_next = vgts_pkg::ST_NB_ADDR;
                else if (last_nb)
                    state_next = vgts_pkg::ST_FINISH;
            vgts_pkg::ST_NB_ADDR: state_next = vgts_pkg::ST_WT_B;
            vgts_pkg::ST_WT_B:
                state_next = is_large ? vgts_pkg::ST_WT_C : vgts_pkg::ST_MEM_USE;
            vgts_pkg::ST_WT_C:    state_next = vgts_pkg::ST_DIV;
            vgts_pkg::ST_DIV:
                if (div_done)
                    state_next = vgts_pkg::ST_MEM_USE;
            vgts_pkg::ST_MEM_USE: state_next = vgts_pkg::ST_ACC;
            vgts_pkg::ST_ACC:
                state_next = last_nb ? vgts_pkg::ST_FINISH : vgts_pkg::ST_NB_CHECK;
            vgts_pkg::ST_FINISH:
                if (!out_valid_reg || !out_stall)
                    state_next = vgts_pkg::ST_IDLE;
            default: state_next = vgts_pkg::ST_IDLE;
        endcase
    end

    // ---------------------------------------------------------------
    // State outputs: memory port, shared multiplier operands, divider start
    // ---------------------------------------------------------------
    logic signed [MA_W-1:0] mul_a;
    logic signed [MB_W-1:0] mul_b;

    always_comb
    begin
        in_stall  = (state_reg != vgts_pkg::ST_IDLE);
        mem_en    = 1'b0;
        mem_we    = 1'b0;
        mem_addr  = addr_reg;
        mem_wdata = splat_sum;
        mul_a     = '0;
        mul_b     = '0;
        div_start = 1'b0;
        unique case (state_reg)
            vgts_pkg::ST_CLEAR:
            begin
                mem_en    = 1'b1;
                mem_we    = 1'b1;
                mem_addr  = clr_cnt_reg;
                mem_wdata = '0;
            end
            vgts_pkg::ST_IDLE:
            begin
                mem_addr  = vidx_addr;
                mem_wdata = value;
                if (accept && vidx_ok)
                begin
                    mem_en = (cmd_in == vgts_pkg::CMD_WRITE) || (cmd_in == vgts_pkg::CMD_READ);
                    mem_we = (cmd_in == vgts_pkg::CMD_WRITE);
                end
            end
            vgts_pkg::ST_LOC_X:
            begin
                mul_a = MA_W'(pos_x_reg);
                mul_b = MB_W'(inv_spacing_reg);
            end
            vgts_pkg::ST_LOC_Y:
            begin
                mul_a = MA_W'(pos_y_reg);
                mul_b = MB_W'(inv_spacing_reg);
            end
            vgts_pkg::ST_LOC_Z:
            begin
                mul_a = MA_W'(pos_z_reg);
                mul_b = MB_W'(inv_spacing_reg);
            end
            vgts_pkg::ST_NB_CHECK:
            begin
                mul_a = MA_W'(wx);
                mul_b = MB_W'(wy);
            end
            vgts_pkg::ST_NB_ADDR:
            begin
                // trilinear: (wx*wy >> 16) * wz; tent: low half of wx*wy times wz
                mul_a = is_large ? MA_W'(prod_reg[20:0]) : MA_W'(prod_reg[32:16]);
                mul_b = MB_W'(wz);
            end
            vgts_pkg::ST_WT_B:
            begin
                mem_en = 1'b1;
                mul_a  = MA_W'(wxy_reg[40:21]);
                mul_b  = MB_W'(wz);
            end
            vgts_pkg::ST_WT_C:
                div_start = 1'b1;
            vgts_pkg::ST_MEM_USE:
            begin
                mul_a = (cmd_reg == vgts_pkg::CMD_SAMPLE) ? MA_W'($signed(rdata))
                                                         : MA_W'(val_reg);
                mul_b = MB_W'(w_reg);
            end
            vgts_pkg::ST_ACC:
            begin
                mem_en = (cmd_reg != vgts_pkg::CMD_SAMPLE);
                mem_we = (cmd_reg != vgts_pkg::CMD_SAMPLE);
            end
            default: ;
        endcase
    end

    // ---------------------------------------------------------------
    // Control registers
    // ---------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= vgts_pkg::ST_CLEAR;
            clr_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == vgts_pkg::ST_CLEAR)
                clr_cnt_reg <= clr_cnt_reg + AW'(1);
            if ((state_reg == vgts_pkg::ST_FINISH) && (!out_valid_reg || !out_stall))
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    // ---------------------------------------------------------------
    // Datapath registers
    // ---------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        prod_reg <= mul_a * mul_b;

        if (accept)
        begin
            cmd_reg   <= cmd_in;
            pos_x_reg <= pos_x;
            pos_y_reg <= pos_y;
            pos_z_reg <= pos_z;
            val_reg   <= value;
            r_reg     <= r_in;
            d_reg     <= vgts_pkg::pow6(r_in);
            rd_ok_reg <= vidx_ok;
        end

        unique case (state_reg)
            vgts_pkg::ST_RD_WAIT:
                rd_res_reg <= rd_ok_reg ? $signed(rdata) : 32'sd0;
            vgts_pkg::ST_LOC_Y:
            begin
                ix_reg <= loc_ip;
                ax_reg <= loc_alpha;
            end
            vgts_pkg::ST_LOC_Z:
            begin
                iy_reg <= loc_ip;
                ay_reg <= loc_alpha;
            end
            vgts_pkg::ST_LOC_END:
            begin
                iz_reg  <= loc_ip;
                az_reg  <= loc_alpha;
                dx_reg  <= off_lo;
                dy_reg  <= off_lo;
                dz_reg  <= off_lo;
                acc_reg <= '0;
            end
            vgts_pkg::ST_NB_CHECK:
            begin
                t_reg <= t_calc;
                if (!nb_in)
                begin
                    dx_reg <= dx_adv;
                    dy_reg <= dy_adv;
                    dz_reg <= dz_adv;
                end
            end
            vgts_pkg::ST_NB_ADDR:
            begin
                addr_reg <= addr_calc;
                wxy_reg  <= prod_reg[40:0];
            end
            vgts_pkg::ST_WT_B:
            begin
                lo_reg <= prod_reg[41:0];
                w_reg  <= prod_reg[32:16];
            end
            vgts_pkg::ST_DIV:
                if (div_done)
                    w_reg <= div_q;
            vgts_pkg::ST_ACC:
            begin
                if (cmd_reg == vgts_pkg::CMD_SAMPLE)
                    acc_reg <= acc_reg + ACW'(prod_reg);
                dx_reg <= dx_adv;
                dy_reg <= dy_adv;
                dz_reg <= dz_adv;
            end
            vgts_pkg::ST_FINISH:
                if (!out_valid_reg || !out_stall)
                begin
                    priority if (cmd_reg == vgts_pkg::CMD_READ)
                        result_value_reg <= rd_res_reg;
                    else if (cmd_reg == vgts_pkg::CMD_SAMPLE)
                        result_value_reg <= vgts_pkg::sat32(
                            64'($signed(acc_reg[ACW-1:16])));
                    else
                        result_value_reg <= '0;
                end
            default: ;
        endcase
    end

    assign out_valid    = out_valid_reg;
    assign result_value = result_value_reg;

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    // memory writes only from the clearing pass, a write word or a splat update
    `VGTS_ASSERT_IMP(a_mem_we_state, clk, rst_n, mem_we, (state_reg == vgts_pkg::ST_CLEAR) || (state_reg == vgts_pkg::ST_IDLE) || (state_reg == vgts_pkg::ST_ACC))
    // the divider finishes only while the sequencer waits for it
    `VGTS_ASSERT_IMP(a_div_done_wait, clk, rst_n, div_done, state_reg == vgts_pkg::ST_DIV)
    // an accepted word always leaves idle
    `VGTS_ASSERT_NEXT(a_accept_busy, clk, rst_n, accept, state_reg != vgts_pkg::ST_IDLE)
    // a new result comes only out of the finish step
    `VGTS_ASSERT_IMP(a_out_from_finish, clk, rst_n, $rose(out_valid_reg), $past(state_reg) == vgts_pkg::ST_FINISH)

endmodule

// ===== design/vgts_store.sv =====
// Single-port voxel memory, registered read data.
// No dependencies.
module vgts_store #(
    parameter int DEPTH = 32768,
    parameter int AW    = 15
) (
    input  logic          clk,
    input  logic          en,
    input  logic          we,
    input  logic [AW-1:0] addr,
    input  logic [31:0]   wdata,
    output logic [31:0]   rdata
);

    logic [31:0] voxel_mem [DEPTH];
    logic [31:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (we)
                voxel_mem[addr] <= wdata;
            else
                rdata_reg <= voxel_mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== design/vgts_div.sv =====
// Restoring divider, one quotient bit per cycle, for the large splat weight.
// Uses vgts_pkg.
module vgts_div (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [vgts_pkg::DVD_W-1:0] dividend,
    input  logic [vgts_pkg::DVS_W-1:0] divisor,
    output logic [vgts_pkg::QW-1:0]    quotient,
    output logic                       done
);

    localparam int CNTW = $clog2(vgts_pkg::QW);
    localparam int TRW  = vgts_pkg::DVS_W + vgts_pkg::QW;

    logic [vgts_pkg::DVD_W-1:0] rem_reg;
    logic [vgts_pkg::QW-1:0]    quo_reg;
    logic [CNTW-1:0]            cnt_reg;
    logic                       busy_reg;
    logic                       done_reg;
    logic [TRW-1:0]             trial;
    logic                       take;

    always_comb
    begin
        trial = TRW'(divisor) << cnt_reg;
        take  = TRW'(rem_reg) >= trial;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNTW'(vgts_pkg::QW - 1);
            end
            else if (busy_reg)
            begin
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                    cnt_reg <= cnt_reg - CNTW'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= dividend;
            quo_reg <= '0;
        end
        else if (busy_reg && take)
        begin
            rem_reg          <= rem_reg - trial[vgts_pkg::DVD_W-1:0];
            quo_reg[cnt_reg] <= 1'b1;
        end
    end

    assign quotient = quo_reg;
    assign done     = done_reg;

endmodule
